### rtl/wgli_pkg.sv
// Shared constants, codes and types for the windowed gain/loss index unit.
// No dependencies; used by wgli_div and windowed_gain_loss_index_unit.
package wgli_pkg;

  parameter int WINDOW_MAX_DEFAULT = 64;
  parameter int PRICE_BITS_DEFAULT = 32;

  parameter int PRICE_PORT_BITS = 32;
  parameter int WINDOW_LEN_BITS = 7;
  parameter logic [WINDOW_LEN_BITS-1:0] WINDOW_LEN_RESET = 7'd14;

  parameter int INDEX_BITS  = 10;
  parameter int CLASS_BITS  = 2;
  parameter int QUOT_BITS   = 11;
  parameter int INDEX_SCALE = 1000;
  parameter int HIGH_LIMIT  = 650;
  parameter int LOW_LIMIT   = 350;

  typedef enum logic [CLASS_BITS-1:0] {
    CLASS_NEUTRAL = 2'd0,
    CLASS_LOW     = 2'd1,
    CLASS_HIGH    = 2'd2
  } trend_class_t;

  typedef struct packed {
    logic                  done;
    logic [INDEX_BITS-1:0] index_tenths;
    trend_class_t          trend_class;
  } div_result_t;

endpackage

### rtl/wgli_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wgli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/wgli_div.sv
// Iterative restoring divider: 1000*gain / total, one quotient bit per cycle,
// then rounding and trend classification. Depends on wgli_pkg.
module wgli_div #(
  parameter int SUM_BITS = 38
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [SUM_BITS-1:0]         gain,
  input  logic [SUM_BITS-1:0]         total,
  output wgli_pkg::div_result_t       res
);

  localparam int QB   = wgli_pkg::QUOT_BITS;
  localparam int NW   = SUM_BITS + QB - 1;
  localparam int CNTW = $clog2(QB);

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_STEP = 3'b010,
    DV_FIN  = 3'b100
  } div_state_t;

  div_state_t            state;
  logic [NW-1:0]         num;
  logic [NW-1:0]         den;
  logic [SUM_BITS-1:0]   total_q;
  logic [QB-1:0]         quot;
  logic [CNTW-1:0]       step_cnt;

  logic                  fits;
  logic [SUM_BITS-1:0]   rem;
  logic                  round_up;
  logic [QB-1:0]         idx_full;
  wgli_pkg::trend_class_t cls;

  always_comb begin
    fits     = num >= den;
    rem      = num[SUM_BITS-1:0];
    round_up = {rem, 1'b0} >= {1'b0, total_q};
    idx_full = quot + QB'(round_up);
    if (quot > QB'(wgli_pkg::HIGH_LIMIT) ||
        (quot == QB'(wgli_pkg::HIGH_LIMIT) && rem != '0)) begin
      cls = wgli_pkg::CLASS_HIGH;
    end else if (quot < QB'(wgli_pkg::LOW_LIMIT)) begin
      cls = wgli_pkg::CLASS_LOW;
    end else begin
      cls = wgli_pkg::CLASS_NEUTRAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= DV_IDLE;
      res.done         <= 1'b0;
      res.index_tenths <= '0;
      res.trend_class  <= wgli_pkg::CLASS_NEUTRAL;
    end else begin
      res.done <= 1'b0;
      unique case (state)
        DV_IDLE: begin
          if (start) begin
            state <= DV_STEP;
          end
        end
        DV_STEP: begin
          if (step_cnt == '0) begin
            state <= DV_FIN;
          end
        end
        DV_FIN: begin
          res.done <= 1'b1;
          state    <= DV_IDLE;
          if (total_q == '0) begin
            res.index_tenths <= '0;
            res.trend_class  <= wgli_pkg::CLASS_LOW;
          end else begin
            res.index_tenths <= idx_full[wgli_pkg::INDEX_BITS-1:0];
            res.trend_class  <= cls;
          end
        end
        default: state <= DV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      DV_IDLE: begin
        if (start) begin
          num      <= NW'(gain) * NW'(wgli_pkg::INDEX_SCALE);
          den      <= NW'(total) << (QB - 1);
          total_q  <= total;
          quot     <= '0;
          step_cnt <= CNTW'(QB - 1);
        end
      end
      DV_STEP: begin
        if (fits) begin
          num <= num - den;
        end
        quot     <= {quot[QB-2:0], fits};
        den      <= den >> 1;
        step_cnt <= step_cnt - CNTW'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/windowed_gain_loss_index_unit.sv
// Windowed gain/loss index: one price per beat in, one index per full window out.
// A price that yields a result holds in_stall through the update and the 11-step
// divider, until its result is loaded into the output register; a warm-up
// price holds it through the update only. Synchronous reset clears the stream
// and sets window_len to 14; a config write restarts the stream.
module windowed_gain_loss_index_unit #(
  parameter int WINDOW_MAX = wgli_pkg::WINDOW_MAX_DEFAULT,
  parameter int PRICE_BITS = wgli_pkg::PRICE_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [wgli_pkg::WINDOW_LEN_BITS-1:0] cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [wgli_pkg::PRICE_PORT_BITS-1:0] price,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [wgli_pkg::INDEX_BITS-1:0]      index_tenths,
  output logic [wgli_pkg::CLASS_BITS-1:0]      trend_class
);

  localparam int WLB = wgli_pkg::WINDOW_LEN_BITS;
  localparam int AW  = $clog2(WINDOW_MAX);
  localparam int KW  = $clog2(WINDOW_MAX + 1);
  localparam int CW  = (KW > WLB) ? KW : WLB;
  localparam int DW  = PRICE_BITS + 1;
  localparam int SW  = PRICE_BITS + AW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_UPD  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t                  state;
  state_t                  state_next;
  logic [WLB-1:0]          window_len;
  logic [PRICE_BITS-1:0]   prev;
  logic [DW-1:0]           diff;
  logic [AW-1:0]           old_addr_q;
  logic [AW-1:0]           ptr;
  logic [CW-1:0]           seen;
  logic [SW-1:0]           gain_sum;
  logic [SW-1:0]           loss_sum;
  logic [WINDOW_MAX-1:0]   slot_valid;
  logic                    div_start;
  logic [DW-1:0]           ram_rdata;
  wgli_pkg::div_result_t   res;

  logic                    in_accept;
  logic                    out_free;
  logic                    out_load;
  logic [CW-1:0]           wl_ext;
  logic [CW-1:0]           k;
  logic [CW-1:0]           span;
  logic [CW-1:0]           seen_inc;
  logic                    full_window;
  logic [PRICE_BITS-1:0]   p_in;
  logic [DW-1:0]           diff_in;
  logic [CW:0]             ptr_ext;
  logic [CW:0]             span_ext;
  logic [CW:0]             old_full;
  logic [AW-1:0]           old_addr;
  logic [AW:0]             ptr_sum;
  logic [AW-1:0]           ptr_adv;
  logic [DW-1:0]           old_diff;
  logic [DW-1:0]           old_neg;
  logic [DW-1:0]           new_neg;
  logic [SW-1:0]           old_gain;
  logic [SW-1:0]           old_loss;
  logic [SW-1:0]           new_gain;
  logic [SW-1:0]           new_loss;
  logic [SW-1:0]           total;

  always_comb begin
    in_stall    = state != S_IDLE;
    in_accept   = in_valid && !in_stall;
    out_free    = !out_valid || !out_stall;
    wl_ext      = CW'(window_len);
    if (wl_ext == '0) begin
      k = CW'(1);
    end else if (wl_ext > CW'(WINDOW_MAX)) begin
      k = CW'(WINDOW_MAX);
    end else begin
      k = wl_ext;
    end
    span        = k - CW'(1);
    seen_inc    = (seen < k) ? seen + CW'(1) : seen;
    full_window = seen_inc >= k;
    p_in        = PRICE_BITS'(price);
    diff_in     = (seen != '0) ? DW'(p_in) - DW'(prev) : '0;
    ptr_ext     = (CW + 1)'(ptr);
    span_ext    = (CW + 1)'(span);
    old_full    = (ptr_ext >= span_ext) ? ptr_ext - span_ext
                                        : ptr_ext + (CW + 1)'(WINDOW_MAX) - span_ext;
    old_addr    = old_full[AW-1:0];
    ptr_sum     = {1'b0, ptr} + (AW + 1)'(1);
    ptr_adv     = (ptr_sum >= (AW + 1)'(WINDOW_MAX)) ? '0 : ptr_sum[AW-1:0];
    old_diff    = slot_valid[old_addr_q] ? ram_rdata : '0;
    old_neg     = -old_diff;
    new_neg     = -diff;
    old_gain    = old_diff[DW-1] ? '0 : SW'(old_diff[DW-2:0]);
    old_loss    = old_diff[DW-1] ? SW'(old_neg[DW-2:0]) : '0;
    new_gain    = diff[DW-1] ? '0 : SW'(diff[DW-2:0]);
    new_loss    = diff[DW-1] ? SW'(new_neg[DW-2:0]) : '0;
    total       = gain_sum + loss_sum;
    out_load    = ((state == S_DIV) && res.done && out_free) ||
                  ((state == S_OUT) && out_free);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        state_next = full_window ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (res.done) begin
          state_next = out_free ? S_IDLE : S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      window_len <= wgli_pkg::WINDOW_LEN_RESET;
      prev       <= '0;
      ptr        <= '0;
      seen       <= '0;
      gain_sum   <= '0;
      loss_sum   <= '0;
      slot_valid <= '0;
      div_start  <= 1'b0;
    end else if (cfg_we) begin
      window_len <= cfg_wdata;
      prev       <= '0;
      ptr        <= '0;
      seen       <= '0;
      gain_sum   <= '0;
      loss_sum   <= '0;
      slot_valid <= '0;
      div_start  <= 1'b0;
    end else begin
      state     <= state_next;
      div_start <= (state == S_UPD) && full_window;
      if (in_accept) begin
        prev <= p_in;
      end
      if (state == S_UPD) begin
        seen <= seen_inc;
        if (span != '0) begin
          gain_sum        <= gain_sum - old_gain + new_gain;
          loss_sum        <= loss_sum - old_loss + new_loss;
          slot_valid[ptr] <= 1'b1;
          ptr             <= ptr_adv;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      diff       <= diff_in;
      old_addr_q <= old_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      index_tenths <= res.index_tenths;
      trend_class  <= res.trend_class;
    end
  end

  wgli_ram #(
    .WIDTH (DW),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk     (clk),
    .we      ((state == S_UPD) && (span != '0) && !cfg_we),
    .wr_addr (ptr),
    .wr_data (diff),
    .rd_en   (in_accept),
    .rd_addr (old_addr),
    .rd_data (ram_rdata)
  );

  wgli_div #(
    .SUM_BITS (SW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .gain  (gain_sum),
    .total (total),
    .res   (res)
  );

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    res.done |-> state == S_DIV)
    else $error("divider result outside divide phase");

  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    seen <= k)
    else $error("seen count beyond window");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> index_tenths <= wgli_pkg::INDEX_BITS'(wgli_pkg::INDEX_SCALE))
    else $error("index above full scale");

  a_high_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && trend_class == wgli_pkg::CLASS_HIGH |->
      index_tenths >= wgli_pkg::INDEX_BITS'(wgli_pkg::HIGH_LIMIT))
    else $error("high class with low index");

  a_accept_update: assert property (@(posedge clk) disable iff (rst)
    in_accept && !cfg_we |=> state == S_UPD)
    else $error("accepted beat did not start update");

endmodule
